// File: rtl/core/bdt_pkg.sv
`default_nettype none

package bdt_pkg;

  localparam int unsigned BDT_TICKS_W     = 16;
  localparam int unsigned BDT_LOCKOUT_W   = 16;
  localparam int unsigned BDT_CFG_INDEX_W = 3;
  localparam int unsigned BDT_CFG_DATA_W  = 16;

  typedef enum logic [BDT_CFG_INDEX_W-1:0] {
    REG_LOCKOUT_TICKS  = 3'd0,
    REG_FILTER_MODE    = 3'd1,
    REG_POLARITY_FLIP  = 3'd2,
    REG_PRESS_NOTIFY   = 3'd3,
    REG_RELEASE_NOTIFY = 3'd4,
    REG_TOGGLE_NOTIFY  = 3'd5
  } bdt_reg_t;

  localparam logic MODE_STANDARD = 1'b0;
  localparam logic MODE_TOGGLE   = 1'b1;

  typedef struct packed {
    logic pin_level;
    logic read_change;
  } bdt_in_t;

  typedef struct packed {
    logic pressed_now;
    logic change_seen;
    logic press_event;
    logic release_event;
    logic toggle_event;
  } bdt_out_t;

endpackage

`default_nettype wire

// File: rtl/core/bdt_core.sv
`default_nettype none

module bdt_core #(
  parameter int unsigned LockoutWidth = bdt_pkg::BDT_LOCKOUT_W
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 step_en,
  input  wire bdt_pkg::bdt_in_t                     step_in,
  output bdt_pkg::bdt_out_t                         step_out,
  input  wire logic                                 cfg_we,
  input  wire logic [bdt_pkg::BDT_CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bdt_pkg::BDT_CFG_DATA_W-1:0]   cfg_data
);
  import bdt_pkg::*;

  logic [BDT_TICKS_W-1:0]  ticks_r;
  logic                    mode_r;
  logic                    polarity_r;
  logic                    press_en_r;
  logic                    release_en_r;
  logic                    toggle_en_r;

  logic [LockoutWidth-1:0] lockout_r;
  logic [LockoutWidth-1:0] lockout_nxt;
  logic [LockoutWidth-1:0] lockout_load;
  logic                    last_raw_r;
  logic                    last_raw_nxt;
  logic                    deb_r;
  logic                    deb_nxt;
  logic                    pend_r;
  logic                    pend_nxt;

  logic                    cnt_zero;
  logic                    raw_edge;
  logic                    lvl;
  logic                    deb_step;
  logic                    pend_step;
  logic                    ev_press;
  logic                    ev_release;
  logic                    ev_toggle;
  logic                    pend_after_ev;

  // A narrow counter saturates the programmed lockout length.
  generate
    if (LockoutWidth >= BDT_TICKS_W) begin : g_wide
      assign lockout_load = LockoutWidth'(ticks_r);
    end else begin : g_narrow
      localparam logic [BDT_TICKS_W-1:0] MaxTicks =
        BDT_TICKS_W'((64'd1 << LockoutWidth) - 64'd1);
      assign lockout_load = (ticks_r > MaxTicks) ? '1 : ticks_r[LockoutWidth-1:0];
    end
  endgenerate

  always_comb begin
    cnt_zero   = (lockout_r == '0);
    raw_edge   = cnt_zero && (step_in.pin_level != last_raw_r);
    lvl        = step_in.pin_level ^ polarity_r;

    deb_step     = deb_r;
    pend_step    = pend_r;
    last_raw_nxt = last_raw_r;
    lockout_nxt  = lockout_r;

    if (!cnt_zero) begin
      lockout_nxt = lockout_r - 1'b1;
    end else if (raw_edge) begin
      last_raw_nxt = step_in.pin_level;
      lockout_nxt  = lockout_load;
      if (mode_r == MODE_STANDARD) begin
        deb_step  = lvl;
        pend_step = 1'b1;
      end else if (lvl) begin
        deb_step  = ~deb_r;
        pend_step = 1'b1;
      end
    end

    ev_press      = pend_step && deb_step && press_en_r;
    ev_release    = pend_step && !deb_step && release_en_r;
    ev_toggle     = pend_step && (mode_r == MODE_TOGGLE) && toggle_en_r;
    pend_after_ev = pend_step && !(ev_press || ev_release || ev_toggle);

    step_out.pressed_now   = deb_step;
    step_out.change_seen   = step_in.read_change && pend_after_ev;
    step_out.press_event   = ev_press;
    step_out.release_event = ev_release;
    step_out.toggle_event  = ev_toggle;

    pend_nxt = pend_after_ev && !step_in.read_change;
    deb_nxt  = deb_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r      <= '0;
      mode_r       <= MODE_STANDARD;
      polarity_r   <= 1'b0;
      press_en_r   <= 1'b0;
      release_en_r <= 1'b0;
      toggle_en_r  <= 1'b0;
      lockout_r    <= '0;
      last_raw_r   <= 1'b1;
      deb_r        <= 1'b0;
      pend_r       <= 1'b0;
    end else if (cfg_we) begin
      // The user must send configuration only while the block is idle; the block itself does not enforce it.
      case (cfg_index)
        REG_LOCKOUT_TICKS:  ticks_r      <= cfg_data[BDT_TICKS_W-1:0];
        REG_FILTER_MODE:    mode_r       <= cfg_data[0];
        REG_POLARITY_FLIP: begin
          // A new polarity flips the stored state without raising a change.
          if (cfg_data[0] != polarity_r) begin
            deb_r <= ~deb_r;
          end
          polarity_r <= cfg_data[0];
        end
        REG_PRESS_NOTIFY:   press_en_r   <= cfg_data[0];
        REG_RELEASE_NOTIFY: release_en_r <= cfg_data[0];
        REG_TOGGLE_NOTIFY:  toggle_en_r  <= cfg_data[0];
        default: ;
      endcase
    end else if (step_en) begin
      lockout_r  <= lockout_nxt;
      last_raw_r <= last_raw_nxt;
      deb_r      <= deb_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bdt_out_reg.sv
`default_nettype none

module bdt_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire bdt_pkg::bdt_out_t  load_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output bdt_pkg::bdt_out_t       out_data,
  output logic                    busy
);
  import bdt_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  bdt_out_t data_r;

  // The register can take a new result whenever the held one leaves this cycle.
  assign busy      = valid_r && out_stall;
  assign valid_nxt = load || busy;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_toggle.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   bdt_in_t  (pin_level, read_change)
// out_      output     out_valid / out_stall bdt_out_t (state, change, events)
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each tick request is accepted while in_stall is low, and its result appears in
// the output register in the cycle after; one request per cycle is sustained
// while out_stall is low. The single result register follows the state update.
// Reset is synchronous and active low; no clearing pass is needed.
// in_stall is raised only while a held result is stalled at the output.
// cfg_ready is always high.

module button_debounce_toggle #(
  parameter int unsigned LockoutWidth = bdt_pkg::BDT_LOCKOUT_W
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire bdt_pkg::bdt_in_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output bdt_pkg::bdt_out_t                         out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bdt_pkg::BDT_CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bdt_pkg::BDT_CFG_DATA_W-1:0]   cfg_data
);
  import bdt_pkg::*;

  logic     accept;
  logic     busy;
  bdt_out_t step_out;

  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign cfg_ready = 1'b1;

  bdt_core #(
    .LockoutWidth(LockoutWidth)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .step_in  (in_data),
    .step_out (step_out),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  bdt_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .load_data(step_out),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .busy     (busy)
  );

endmodule

`default_nettype wire
